/* src/dbums_pkg.sv */
// Package with the types and fixed widths that the diagonal band scan shares.
`default_nettype none

package dbums_pkg;

    localparam int GROUP_W    = 4;
    localparam int NUM_GROUPS = 1 << GROUP_W;
    localparam int SCORE_W    = 8;
    localparam int NUM_FIELDS = 8;

    // One request: a group of diagonals at one subject row.
    typedef struct packed {
        logic [GROUP_W-1:0]        group;
        logic                      first_row;
        logic                      last_row;
        logic signed [SCORE_W-1:0] score_0;
        logic signed [SCORE_W-1:0] score_1;
        logic signed [SCORE_W-1:0] score_2;
        logic signed [SCORE_W-1:0] score_3;
        logic signed [SCORE_W-1:0] score_4;
        logic signed [SCORE_W-1:0] score_5;
        logic signed [SCORE_W-1:0] score_6;
        logic signed [SCORE_W-1:0] score_7;
    } t_item;

    // One result: the best scores of a group's lanes.
    typedef struct packed {
        logic [GROUP_W-1:0] out_group;
        logic [SCORE_W-1:0] best_0;
        logic [SCORE_W-1:0] best_1;
        logic [SCORE_W-1:0] best_2;
        logic [SCORE_W-1:0] best_3;
        logic [SCORE_W-1:0] best_4;
        logic [SCORE_W-1:0] best_5;
        logic [SCORE_W-1:0] best_6;
        logic [SCORE_W-1:0] best_7;
    } t_result;

    // Control that every lane sees for an accepted request.
    typedef struct packed {
        logic               upd;
        logic               first;
        logic [GROUP_W-1:0] group;
    } t_lane_ctl;

endpackage

`default_nettype wire

/* src/dbums_if.sv */
// Valid/ready channel interfaces for requests and results.
`default_nettype none

interface dbums_item_if
    import dbums_pkg::*;
    ();
    logic  valid;
    logic  ready;
    t_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dbums_result_if
    import dbums_pkg::*;
    ();
    logic    valid;
    logic    ready;
    t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/diagonal_band_ungapped_max_scan.sv */
// Top level of the diagonal band ungapped maximum scan.
//
//  Channel  Direction  Carries
//  i_req    in         group, first_row, last_row and eight signed lane scores
//  o_res    out        out_group and eight saturated best scores (last_row only)
//
// A request is taken in every cycle while the result buffer has a free slot, so the
// sustained rate is one request per cycle. Each lane reads its running and best score
// for the addressed group, updates them and writes them back within the same cycle,
// so a request for the same group may follow in the very next cycle.
// The result of a request with last_row is registered before it appears on o_res.
// Reset clears only the handshake state; the score stores hold nothing defined until a
// group is started with first_row. A stalled o_res fills the second result slot, and
// only then is i_req held off.
`default_nettype none

module diagonal_band_ungapped_max_scan
    import dbums_pkg::*;
#(
    parameter int BAND  = 128,
    parameter int LANES = 8
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    dbums_item_if.sink     i_req,
    dbums_result_if.source o_res
);

    logic                               w_fire;
    logic                               w_ready;
    t_lane_ctl                          w_ctl;
    logic [NUM_FIELDS-1:0][SCORE_W-1:0] w_score;
    logic [NUM_FIELDS-1:0][SCORE_W-1:0] w_best;

    // A request is accepted whenever the merging stage still has a free slot.
    assign i_req.ready = w_ready;
    assign w_fire      = i_req.valid && w_ready;

    assign w_ctl.upd   = w_fire;
    assign w_ctl.first = i_req.data.first_row;
    assign w_ctl.group = i_req.data.group;

    assign w_score[0] = i_req.data.score_0;
    assign w_score[1] = i_req.data.score_1;
    assign w_score[2] = i_req.data.score_2;
    assign w_score[3] = i_req.data.score_3;
    assign w_score[4] = i_req.data.score_4;
    assign w_score[5] = i_req.data.score_5;
    assign w_score[6] = i_req.data.score_6;
    assign w_score[7] = i_req.data.score_7;

    // One lane per diagonal of the group; score fields beyond LANES are ignored and
    // their result fields read as zero.
    for (genvar k = 0; k < NUM_FIELDS; k++) begin : g_lane
        if (k < LANES) begin : g_on
            dbums_lane #(
                .BAND     (BAND),
                .LANES    (LANES),
                .LANE_IDX (k)
            ) u_lane (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl),
                .i_score (w_score[k]),
                .o_best  (w_best[k])
            );
        end else begin : g_off
            assign w_best[k] = '0;
        end
    end

    dbums_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_fire && i_req.data.last_row),
        .i_group (i_req.data.group),
        .i_best  (w_best),
        .o_ready (w_ready),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

/* src/dbums_lane.sv */
// One lane: running and best score store for one diagonal per group, with update logic.
`default_nettype none

module dbums_lane
    import dbums_pkg::*;
#(
    parameter int BAND     = 128,
    parameter int LANES    = 8,
    parameter int LANE_IDX = 0
) (
    input  wire logic                      i_clk,
    input  wire t_lane_ctl                 i_ctl,
    input  wire logic signed [SCORE_W-1:0] i_score,
    output logic [SCORE_W-1:0]             o_best
);

    // Groups whose diagonal for this lane lies inside the band.
    localparam int GLIM   = (BAND - LANE_IDX + LANES - 1) / LANES;
    localparam int ROWS   = (GLIM < NUM_GROUPS) ? GLIM : NUM_GROUPS;
    localparam int ADDR_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SUM_W  = SCORE_W + 2;

    logic [SCORE_W-1:0] r_run  [ROWS];
    logic [SCORE_W-1:0] r_best [ROWS];

    logic                    w_in_band;
    logic [ADDR_W-1:0]       w_addr;
    logic [SCORE_W-1:0]      w_run_old;
    logic [SCORE_W-1:0]      w_best_old;
    logic signed [SUM_W-1:0] w_sum;
    logic [SCORE_W-1:0]      n_run;
    logic [SCORE_W-1:0]      n_best;

    assign w_in_band = (int'(i_ctl.group) < GLIM);
    assign w_addr    = i_ctl.group[ADDR_W-1:0];

    always_comb begin
        w_run_old  = i_ctl.first ? '0 : r_run[w_addr];
        w_best_old = i_ctl.first ? '0 : r_best[w_addr];
        w_sum = $signed({2'b00, w_run_old})
              + $signed({{2{i_score[SCORE_W-1]}}, i_score});
        if (w_sum[SUM_W-1]) begin
            n_run = '0;
        end else if (w_sum[SUM_W-2]) begin
            n_run = '1;
        end else begin
            n_run = w_sum[SCORE_W-1:0];
        end
        n_best = (n_run > w_best_old) ? n_run : w_best_old;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.upd && w_in_band) begin
            r_run[w_addr]  <= n_run;
            r_best[w_addr] <= n_best;
        end
    end

    assign o_best = w_in_band ? n_best : '0;

endmodule

`default_nettype wire

/* src/dbums_merge.sv */
// Merging stage: packs the lanes' best scores into a result and buffers it in two slots.
`default_nettype none

module dbums_merge
    import dbums_pkg::*;
(
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_push,
    input  wire logic [GROUP_W-1:0]                i_group,
    input  wire logic [NUM_FIELDS-1:0][SCORE_W-1:0] i_best,
    output logic                                   o_ready,
    dbums_result_if.source                         o_res
);

    t_result r_out;
    t_result r_skid;
    logic    r_out_valid;
    logic    r_skid_valid;
    t_result n_out;
    t_result n_skid;
    logic    n_out_valid;
    logic    n_skid_valid;
    t_result w_new;

    always_comb begin
        w_new.out_group = i_group;
        w_new.best_0    = i_best[0];
        w_new.best_1    = i_best[1];
        w_new.best_2    = i_best[2];
        w_new.best_3    = i_best[3];
        w_new.best_4    = i_best[4];
        w_new.best_5    = i_best[5];
        w_new.best_6    = i_best[6];
        w_new.best_7    = i_best[7];
    end

    always_comb begin
        n_out        = r_out;
        n_skid       = r_skid;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (!r_out_valid || o_res.ready) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out       = w_new;
                n_out_valid = i_push;
            end
        end else if (i_push) begin
            n_skid       = w_new;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_ready     = !r_skid_valid;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

endmodule

`default_nettype wire

/* src/dbums_checker.sv */
// Port-level checks for the diagonal band scan, bound to the top level.
`default_nettype none

module dbums_checker
    import dbums_pkg::*;
(
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    i_in_valid,
    input wire logic    i_in_ready,
    input wire logic    i_in_last,
    input wire logic    i_out_valid,
    input wire logic    i_out_ready,
    input wire t_result i_out_data
);

    logic w_in_fire;
    assign w_in_fire = i_in_valid && i_in_ready;

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its contents.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> $stable(i_out_data))
        else $error("stalled result changed");

    // A fresh result follows a request that carried last_row.
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !$past(i_out_valid)) |-> $past(w_in_fire && i_in_last))
        else $error("result without a last_row request");

    // A result stored behind a stalled one fills the buffer.
    a_skid_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready && w_in_fire && i_in_last) |=> !i_in_ready)
        else $error("buffer did not fill");

    // Requests are held off only while a result waits.
    a_hold_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("requests held off with no result pending");

endmodule

bind diagonal_band_ungapped_max_scan dbums_checker u_dbums_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_in_last   (i_req.data.last_row),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.data)
);

`default_nettype wire

/* dv/tb.sv */
// Self-checking testbench for the diagonal band ungapped maximum scan.
`timescale 1ns / 100ps

module tb;
    import dbums_pkg::*;

    localparam int BAND_C  = 128;
    localparam int LANES_C = 8;

    // Score shapes used when drawing a row of lane scores.
    typedef enum int {
        SHAPE_MIX,     // uniform over the whole signed range
        SHAPE_CLIMB,   // mostly positive, drives lanes into saturation
        SHAPE_SINK,    // negative, drives lanes to the zero floor
        SHAPE_EDGES    // only the extreme and near-zero values
    } t_shape;

    typedef logic signed [SCORE_W-1:0] t_lane_scores [NUM_FIELDS];

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    dbums_item_if   req_if ();
    dbums_result_if res_if ();

    diagonal_band_ungapped_max_scan #(
        .BAND  (BAND_C),
        .LANES (LANES_C)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: our own copy of every diagonal's running and best score.
    logic [SCORE_W-1:0] run_sc  [BAND_C];
    logic [SCORE_W-1:0] best_sc [BAND_C];

    t_item   pend_q [$];      // requests waiting to be offered on i_req
    t_result best_q [$];      // best-score results still owed by the block

    int  n_acc   = 0;
    int  n_res   = 0;
    int  n_bad   = 0;
    int  n_sat   = 0;
    int  n_floor = 0;
    logic calm;

    // Generator bookkeeping: which groups have been started with first_row, how
    // many rows the current sequence of each group still has, and its score shape.
    bit     live   [NUM_GROUPS];
    int     left   [NUM_GROUPS];
    t_shape shape  [NUM_GROUPS];

    // A window of requests with no idling on either side of the block.
    assign calm = (n_acc >= 220) && (n_acc < 340);

    function automatic logic signed [SCORE_W-1:0] lane_score(t_item it, int k);
        case (k)
            0: return it.score_0;
            1: return it.score_1;
            2: return it.score_2;
            3: return it.score_3;
            4: return it.score_4;
            5: return it.score_5;
            6: return it.score_6;
            default: return it.score_7;
        endcase
    endfunction

    function automatic logic [SCORE_W-1:0] lane_best(t_result r, int k);
        case (k)
            0: return r.best_0;
            1: return r.best_1;
            2: return r.best_2;
            3: return r.best_3;
            4: return r.best_4;
            5: return r.best_5;
            6: return r.best_6;
            default: return r.best_7;
        endcase
    endfunction

    // Apply one accepted request to the predictor and, on last_row, queue the
    // group's best scores as the next expected result.
    function void scan_row(t_item it);
        logic [SCORE_W-1:0] b [NUM_FIELDS];
        t_result            r;
        int                 idx;
        int                 v;
        for (int k = 0; k < NUM_FIELDS; k++) begin
            idx  = int'(it.group) * LANES_C + k;
            b[k] = '0;
            if (k < LANES_C && idx < BAND_C) begin
                if (it.first_row) begin
                    run_sc[idx]  = '0;
                    best_sc[idx] = '0;
                end
                v = int'(run_sc[idx]) + int'(lane_score(it, k));
                if (v < 0) begin
                    v = 0;
                    n_floor++;
                end
                if (v > 255) begin
                    v = 255;
                    n_sat++;
                end
                run_sc[idx] = SCORE_W'(v);
                if (run_sc[idx] > best_sc[idx]) begin
                    best_sc[idx] = run_sc[idx];
                end
                b[k] = best_sc[idx];
            end
        end
        if (it.last_row) begin
            r.out_group = it.group;
            r.best_0    = b[0];
            r.best_1    = b[1];
            r.best_2    = b[2];
            r.best_3    = b[3];
            r.best_4    = b[4];
            r.best_5    = b[5];
            r.best_6    = b[6];
            r.best_7    = b[7];
            best_q.push_back(r);
        end
    endfunction

    function void report_field(string what, int want, int got);
        n_bad++;
        if (n_bad <= 10) begin
            $display("mismatch on %s: expected %0d, got %0d", what, want, got);
        end
    endfunction

    function void check_result(t_result got);
        t_result want;
        if (best_q.size() == 0) begin
            n_bad++;
            if (n_bad <= 10) begin
                $display("unexpected result for group %0d", got.out_group);
            end
            return;
        end
        want = best_q.pop_front();
        n_res++;
        if (got.out_group !== want.out_group) begin
            report_field("out_group", int'(want.out_group), int'(got.out_group));
        end
        for (int k = 0; k < NUM_FIELDS; k++) begin
            if (lane_best(got, k) !== lane_best(want, k)) begin
                report_field($sformatf("best_%0d of group %0d", k, want.out_group),
                             int'(lane_best(want, k)), int'(lane_best(got, k)));
            end
        end
    endfunction

    function automatic t_lane_scores draw_scores(t_shape sh);
        t_lane_scores s;
        for (int k = 0; k < NUM_FIELDS; k++) begin
            case (sh)
                SHAPE_CLIMB: begin
                    if ($urandom_range(0, 9) < 8) begin
                        s[k] = SCORE_W'($urandom_range(20, 127));
                    end else begin
                        s[k] = SCORE_W'($urandom);
                    end
                end
                SHAPE_SINK: begin
                    s[k] = {1'b1, 7'($urandom)};
                end
                SHAPE_EDGES: begin
                    case ($urandom_range(0, 4))
                        0: s[k] = 8'sh80;
                        1: s[k] = 8'sh7f;
                        2: s[k] = 8'sh00;
                        3: s[k] = 8'shff;
                        default: s[k] = 8'sh01;
                    endcase
                end
                default: begin
                    s[k] = SCORE_W'($urandom);
                end
            endcase
        end
        return s;
    endfunction

    function void queue_row(int g, bit first, bit last, t_lane_scores s);
        t_item it;
        it.group     = GROUP_W'(g);
        it.first_row = first;
        it.last_row  = last;
        it.score_0   = s[0];
        it.score_1   = s[1];
        it.score_2   = s[2];
        it.score_3   = s[3];
        it.score_4   = s[4];
        it.score_5   = s[5];
        it.score_6   = s[6];
        it.score_7   = s[7];
        if (first) begin
            live[g] = 1'b1;
        end
        pend_q.push_back(it);
    endfunction

    // Random requests. Most of them form well-formed sequences per group (first
    // row, some middle rows, last row) that interleave across groups; the rest are
    // noise rows with random flags on groups that have already been started, which
    // gives restarts in mid-sequence and last rows without a first row.
    task automatic scan_random(int count);
        int g;
        for (int n = 0; n < count; n++) begin
            g = $urandom_range(0, NUM_GROUPS - 1);
            if (live[g] && $urandom_range(0, 99) < 12) begin
                queue_row(g, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          draw_scores(t_shape'($urandom_range(0, 3))));
            end else begin
                if (left[g] == 0) begin
                    // The occasional long sequence lets climbing lanes reach 255.
                    left[g]  = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                           : $urandom_range(1, 6);
                    shape[g] = t_shape'($urandom_range(0, 3));
                    queue_row(g, 1'b1, left[g] == 1, draw_scores(shape[g]));
                end else begin
                    queue_row(g, 1'b0, left[g] == 1, draw_scores(shape[g]));
                end
                left[g]--;
            end
        end
    endtask

    // Sampled on the falling edge, so that the decision never races the
    // clocked driver and monitor.
    task automatic wait_drained();
        while (pend_q.size() != 0 || req_if.valid || best_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Driver: offers the oldest pending request, holds it until it is taken, and
    // predicts every request at the edge at which it is accepted.
    always @(posedge i_clk) begin : req_driver
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            req_if.data  <= '0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                scan_row(req_if.data);
                n_acc++;
            end
            if (!req_if.valid || req_if.ready) begin
                if (pend_q.size() != 0 && (calm || $urandom_range(0, 99) >= 30)) begin
                    req_if.data  <= pend_q.pop_front();
                    req_if.valid <= 1'b1;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result and stalls o_res at random.
    always @(posedge i_clk) begin : res_monitor
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                check_result(res_if.data);
            end
            res_if.ready <= calm || ($urandom_range(0, 99) >= 30);
        end
    end

    initial begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
            live[g] = 1'b0;
            left[g] = 0;
        end

        // Directed rows. A single row that both starts and ends a group, at zero
        // and at the largest score.
        queue_row(0, 1'b1, 1'b1, '{default: 8'sh00});
        queue_row(15, 1'b1, 1'b1, '{default: 8'sh7f});
        // Three rows of 127 run past 255 and must hold at 255.
        queue_row(1, 1'b1, 1'b0, '{default: 8'sh7f});
        queue_row(1, 1'b0, 1'b0, '{default: 8'sh7f});
        queue_row(1, 1'b0, 1'b1, '{default: 8'sh7f});
        // The most negative score clamps at zero, and the lane climbs from there.
        queue_row(2, 1'b1, 1'b0, '{default: 8'sh80});
        queue_row(2, 1'b0, 1'b1, '{default: 8'sh01});
        // Mixed lanes: the best score must survive a later drop.
        queue_row(3, 1'b1, 1'b0, '{8'sh7f, 8'sh80, 8'sh00, 8'shff,
                                   8'sh01, 8'sh40, 8'shc0, 8'sh64});
        queue_row(3, 1'b0, 1'b0, '{8'sh32, 8'sh7f, 8'shff, 8'sh01,
                                   8'sh80, 8'sh32, 8'sh7f, 8'sh9c});
        queue_row(3, 1'b0, 1'b1, '{default: 8'sh80});
        // A fresh first row in mid-sequence drops the earlier, higher best.
        queue_row(4, 1'b1, 1'b0, '{default: 8'sh40});
        queue_row(4, 1'b1, 1'b0, '{default: 8'sh10});
        queue_row(4, 1'b0, 1'b1, '{default: 8'sh05});
        // A last row without a first row carries on from the earlier sequence.
        queue_row(15, 1'b0, 1'b1, '{default: 8'sh80});
        // Start the remaining groups so that every one of them holds known scores.
        for (int g = 5; g < 15; g++) begin
            queue_row(g, 1'b1, 1'b0, draw_scores(SHAPE_EDGES));
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait_drained();
        scan_random(400);
        // Hold the sender back until the block has delivered everything owed.
        wait_drained();
        scan_random(350);
        wait_drained();
        repeat (20) @(posedge i_clk);

        $display("Scanned %0d requests over %0d groups; %0d best-score results compared.",
                 n_acc, NUM_GROUPS, n_res);
        $display("Lane updates clamped at the top: %0d, at zero: %0d.", n_sat, n_floor);
        if (n_bad == 0 && best_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
